/* rtl/point_in_polygon_test_assert.svh */
// Assertion macros for the point-in-polygon block.
// Included by the top level; no other dependencies.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH
`ifndef ASSERT_OFF
`define PIP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PIP_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PIP_ASSERT(label, clk, rst_n, prop)
`define PIP_ASSERT_RST(label, clk, prop)
`endif
`endif

/* rtl/pip_pkg.sv */
// Shared types and constants for the point-in-polygon block.
// No dependencies.
package pip_pkg;
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture command word
    logic clr_total;  // empty the store
    logic append;     // write vertex, bump count
    logic rd;         // issue vertex read at index
    logic load_first; // latch read as vertex j for first edge, reset index
    logic edge_eval;  // latch read as vertex i of the current edge
    logic mul;        // register product, on-edge and crossing flags
    logic div_start;  // load divider
    logic div_step;   // one quotient bit
    logic cmp;        // final threshold compare, toggle
    logic adv;        // i -> j, index++
    logic clr_inside;
  } pip_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last;       // index is last vertex
    logic on_edge;    // registered hit on current edge
    logic crosses;    // straddle flag for current edge
    logic div_done;
  } pip_sts_t;
endpackage

/* rtl/pip_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface pip_if #(parameter int W = 1) (input logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/point_in_polygon_test.sv */
// Top level of the point-in-polygon block: channels, controller, datapath.
// Depends on pip_pkg, pip_if, pip_ctrl, pip_dp and the assertion header.
//
// Input channel in_i carries words {cmd, coord_x, coord_y}; output channel
// out_o carries {inside_res, on_edge}. Clear and append give no word.
// A query reads the last stored vertex as the first j and then walks
// every stored edge. Each edge reads a vertex, then evaluates and
// multiplies. When the edge straddles the point it runs a restoring divide
// of 2*COORD_BITS steps; otherwise it skips that wait. It then compares and
// advances. The serial divider and the single memory read port bound the
// query time.
// A hit on an axis-parallel edge ends the walk early.
// Items are handled one at a time; the result sits in an output register
// until taken, and no new word is accepted while it waits.
// Reset empties the store; vertex memory contents are not cleared.
`include "point_in_polygon_test_assert.svh"
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  pip_if.sink   in_i,
  pip_if.source out_o
);
  pip_cmd_t cmd;
  pip_sts_t sts;
  logic     inside_flag;
  logic [1:0] in_cmd;
  logic [COORD_BITS-1:0] in_x, in_y;

  // word layout: {cmd, coord_x, coord_y}
  assign in_cmd = in_i.data[2*COORD_BITS+1 -: 2];
  assign in_x   = in_i.data[2*COORD_BITS-1 -: COORD_BITS];
  assign in_y   = in_i.data[COORD_BITS-1:0];

  pip_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_cmd),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .inside_i    (inside_flag),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_inside_o(out_o.data[1]),
    .out_edge_o  (out_o.data[0])
  );

  pip_dp #(.MaxVertices(MAX_VERTICES), .CoordBits(COORD_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i   (cmd),
    .x_i     (in_x),
    .y_i     (in_y),
    .sts_o   (sts),
    .inside_o(inside_flag)
  );

  `PIP_ASSERT(a_edge_implies_inside, clk_i, rst_ni, out_o.valid && out_o.data[0] |-> out_o.data[1])
  `PIP_ASSERT(a_no_accept_busy, clk_i, rst_ni, out_o.valid |-> !in_i.ready)
  `PIP_ASSERT(a_append_full, clk_i, rst_ni, sts.full && cmd.append |=> sts.full)
endmodule

/* rtl/pip_dp.sv */
// Datapath: vertex memories, edge compare, multiply and restoring divide.
// Depends on pip_pkg.
module pip_dp import pip_pkg::*; #(
  parameter int MaxVertices = 256,
  parameter int CoordBits   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pip_cmd_t             cmd_i,
  input  logic [CoordBits-1:0] x_i,
  input  logic [CoordBits-1:0] y_i,
  output pip_sts_t             sts_o,
  output logic                 inside_o
);
  localparam int AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CW = $clog2(MaxVertices + 1);
  localparam int PW = 2 * CoordBits;
  localparam int QW = $clog2(PW + 1);

  logic [CoordBits-1:0] mem_x [MaxVertices];
  logic [CoordBits-1:0] mem_y [MaxVertices];
  logic [CoordBits-1:0] rdx_q, rdy_q;
  logic [CW-1:0] total_q, idx_q;
  logic [CoordBits-1:0] px_q, py_q, xi_q, yi_q, xj_q, yj_q;
  logic inside_q, hit_q, cross_q, neg_q, dn_q;
  logic [PW-1:0] num_q, quo_q;
  logic [CoordBits:0] rem_q;
  logic [CoordBits-1:0] den_q;
  logic [QW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && total_q < CW'(MaxVertices)) begin
      mem_x[total_q[AW-1:0]] <= x_i;
      mem_y[total_q[AW-1:0]] <= y_i;
    end
    if (cmd_i.rd) begin
      rdx_q <= mem_x[idx_q[AW-1:0]];
      rdy_q <= mem_y[idx_q[AW-1:0]];
    end
  end

  logic [CoordBits-1:0] dxm, dym, dem;
  logic lox, hix, loy, hiy, h, sy_i, sy_j;
  always_comb begin
    dxm = (xj_q < xi_q) ? xi_q - xj_q : xj_q - xi_q;
    dym = (py_q < yi_q) ? yi_q - py_q : py_q - yi_q;
    dem = (yj_q < yi_q) ? yi_q - yj_q : yj_q - yi_q;
    loy = (py_q >= ((yi_q < yj_q) ? yi_q : yj_q));
    hiy = (py_q <= ((yi_q < yj_q) ? yj_q : yi_q));
    lox = (px_q >= ((xi_q < xj_q) ? xi_q : xj_q));
    hix = (px_q <= ((xi_q < xj_q) ? xj_q : xi_q));
    h = ((xi_q == xj_q) && (px_q == xi_q) && loy && hiy) ||
        ((yi_q == yj_q) && (py_q == yi_q) && lox && hix);
    sy_i = yi_q > py_q;
    sy_j = yj_q > py_q;
  end

  logic [CoordBits+1:0] trial;
  assign trial = {rem_q, num_q[PW-1]} - {2'b00, den_q};

  logic signed [CoordBits+1:0] thr;
  always_comb begin
    if (neg_q) thr = $signed({2'b00, xi_q}) - $signed({1'b0, quo_q[CoordBits:0]});
    else       thr = $signed({2'b00, xi_q}) + $signed({1'b0, quo_q[CoordBits:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      idx_q    <= '0;
      inside_q <= 1'b0;
      cnt_q    <= '0;
      dn_q     <= 1'b0;
    end else begin
      if (cmd_i.clr_total) total_q <= '0;
      if (cmd_i.append && total_q < CW'(MaxVertices)) total_q <= total_q + 1'b1;
      if (cmd_i.latch) begin
        px_q  <= x_i;
        py_q  <= y_i;
        idx_q <= (total_q == '0) ? '0 : total_q - 1'b1;
      end
      if (cmd_i.load_first) begin
        xj_q  <= rdx_q;
        yj_q  <= rdy_q;
        idx_q <= '0;
      end
      if (cmd_i.clr_inside) inside_q <= 1'b0;
      if (cmd_i.edge_eval) begin
        xi_q <= rdx_q;
        yi_q <= rdy_q;
      end
      if (cmd_i.mul) begin
        hit_q   <= h;
        cross_q <= (sy_i != sy_j) && (dem != '0);
        neg_q   <= (xj_q < xi_q) ^ (py_q < yi_q) ^ (yj_q < yi_q);
        num_q   <= dxm * dym;
        den_q   <= dem;
      end
      if (cmd_i.div_start) begin
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= QW'(PW);
        dn_q  <= 1'b0;
      end else if (cmd_i.div_step && !dn_q) begin
        if (!trial[CoordBits+1]) begin
          rem_q <= trial[CoordBits:0];
          quo_q <= {quo_q[PW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[CoordBits-1:0], num_q[PW-1]};
          quo_q <= {quo_q[PW-2:0], 1'b0};
        end
        num_q <= {num_q[PW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == QW'(1)) dn_q <= 1'b1;
      end
      if (cmd_i.cmp && $signed({2'b00, px_q}) < thr) inside_q <= ~inside_q;
      if (cmd_i.adv) begin
        xj_q  <= xi_q;
        yj_q  <= yi_q;
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign sts_o.full     = (total_q == CW'(MaxVertices));
  assign sts_o.empty    = (total_q == '0);
  assign sts_o.last     = (idx_q == total_q - 1'b1);
  assign sts_o.on_edge  = hit_q;
  assign sts_o.crosses  = cross_q;
  assign sts_o.div_done = dn_q;
  assign inside_o       = inside_q;
endmodule

/* rtl/pip_ctrl.sv */
// Controller state machine sequencing commands over the datapath.
// Depends on pip_pkg.
module pip_ctrl import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [1:0] in_cmd_i,
  input  pip_sts_t sts_i,
  output pip_cmd_t cmd_o,
  input  logic     inside_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     out_inside_o,
  output logic     out_edge_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_RDJ, S_LDJ, S_RDI, S_LDI, S_EVAL, S_DIV, S_CMP, S_DONE
  } state_e;

  state_e state_q;
  logic   ov_q, oi_q, oe_q;

  logic acc;
  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.latch      = acc;
    cmd_o.clr_total  = acc && in_cmd_i == CMD_CLEAR;
    cmd_o.append     = acc && in_cmd_i == CMD_APPEND;
    cmd_o.clr_inside = acc;
    cmd_o.rd         = (state_q == S_RDJ) || (state_q == S_RDI);
    cmd_o.load_first = state_q == S_LDJ;
    cmd_o.edge_eval  = state_q == S_LDI;
    cmd_o.mul        = state_q == S_EVAL;
    cmd_o.div_start  = state_q == S_EVAL;
    cmd_o.div_step   = state_q == S_DIV;
    cmd_o.cmp        = state_q == S_CMP && sts_i.crosses;
    cmd_o.adv        = state_q == S_CMP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      oi_q    <= 1'b0;
      oe_q    <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (acc && in_cmd_i == CMD_QUERY) begin
          if (sts_i.empty) begin
            ov_q <= 1'b1; oi_q <= 1'b0; oe_q <= 1'b0;
          end else begin
            state_q <= S_RDJ;
          end
        end
        S_RDJ:  state_q <= S_LDJ;
        S_LDJ:  state_q <= S_RDI;
        S_RDI:  state_q <= S_LDI;
        S_LDI:  state_q <= S_EVAL;
        S_EVAL: state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.on_edge) begin
            ov_q <= 1'b1; oi_q <= 1'b1; oe_q <= 1'b1;
            state_q <= S_IDLE;
          end else if (!sts_i.crosses || sts_i.div_done) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: state_q <= sts_i.last ? S_DONE : S_RDI;
        S_DONE: begin
          ov_q <= 1'b1; oi_q <= inside_i; oe_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = ov_q;
  assign out_inside_o = oi_q;
  assign out_edge_o   = oe_q;
endmodule
